/* hw/rtl/lbg_pkg.sv */
// Shared types and constants of the LED bar-graph renderer.
// Used by lbg_ctrl, lbg_dp and led_bar_graph_renderer; depends on nothing.
package lbg_pkg;

    localparam int LED_MAX       = 64;
    localparam int BAND_MAX      = 8;
    localparam int SAMPLE_OFFSET = 15;
    localparam int SAMPLE_TOP    = 1010;
    localparam int SAMPLE_SPAN   = SAMPLE_TOP - SAMPLE_OFFSET;
    // floor(2^RECIP_SHIFT / SAMPLE_SPAN): estimate is low by at most one
    localparam int RECIP_SHIFT   = 20;
    localparam int RECIP         = (1 << RECIP_SHIFT) / SAMPLE_SPAN;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_COUNT    = 3'd0,
        REG_BAND_COUNT   = 3'd1,
        REG_BAND_LIMITS  = 3'd2,
        REG_TAIL_LENGTH  = 3'd3,
        REG_LAYOUT_MODE  = 3'd4,
        REG_PALETTE_LOW  = 3'd5,
        REG_PALETTE_MID  = 3'd6,
        REG_PALETTE_HIGH = 3'd7
    } lbg_reg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;   // capture the accepted request
        logic mul1;    // offset sample times LED count
        logic mul2;    // reciprocal estimate of the quotient
        logic mul3;    // correct and clamp the quotient
        logic update;  // apply the new level, flag a redraw
        logic setup;   // prepare frame constants, clear counters
        logic emit;    // load one LED result into the output stage
    } lbg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pending;   // a redraw is due
        logic out_free;  // output stage can take a result this cycle
        logic last_led;  // frame counter sits on the final LED
    } lbg_stat_t;

endpackage

/* hw/rtl/lbg_ctrl.sv */
// Sequencer of the LED bar-graph renderer: one-hot state machine.
// Depends on lbg_pkg for the command and status structs.
module lbg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lbg_pkg::lbg_stat_t stat,
    output lbg_pkg::lbg_cmd_t  cmd
);
    import lbg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL1   = 7'b0000010,
        ST_MUL2   = 7'b0000100,
        ST_MUL3   = 7'b0001000,
        ST_UPDATE = 7'b0010000,
        ST_SETUP  = 7'b0100000,
        ST_WALK   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (stat.pending) begin
                    cmd.setup  = 1'b1;
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last_led) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/lbg_dp.sv */
// Datapath of the LED bar-graph renderer: config registers, level mapping,
// frame walk and output stage. Depends on lbg_pkg.
module lbg_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lbg_pkg::lbg_cmd_t                   cmd,
    output lbg_pkg::lbg_stat_t                  stat,
    input  logic [lbg_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_we,
    input  logic [lbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lbg_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import lbg_pkg::*;

    // Configuration
    logic [6:0]  led_count_reg;
    logic [3:0]  band_count_reg;
    logic [47:0] band_limits_reg;
    logic [6:0]  tail_length_reg;
    logic [9:0]  layout_reg;
    logic [63:0] pal_low_reg, pal_mid_reg, pal_high_reg;

    // Request and level mapping
    logic        func_reg;
    logic [9:0]  sample_reg;
    logic [7:0]  level_in_reg;
    logic [15:0] prod_reg;
    logic [6:0]  qest_reg;
    logic [6:0]  qfin_reg;
    logic [6:0]  shown_level_reg;
    logic [6:0]  prior_pot_reg;
    logic        pending_reg;

    // Frame walk
    logic [6:0]  lvl_reg;
    logic [6:0]  start_reg;
    logic [2:0]  sband_reg;
    logic [6:0]  idx_reg;
    logic [3:0]  col_reg;
    logic [3:0]  row_reg;
    logic [7:0]  row_base_reg;

    // Output stage
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_last_reg;

    logic [6:0]  leds_eff;
    logic [3:0]  bands_eff;
    logic [9:0]  diff;
    logic [16:0] prod_full;
    logic [26:0] qmul;
    logic [16:0] back;
    logic [16:0] rem;
    logic [6:0]  qcor;
    logic [6:0]  direct_lvl;
    logic [6:0]  lvl_set;
    logic [6:0]  start_set;
    logic [5:0]  sband_pos;
    logic [3:0]  cols, rows;
    logic        full_row;
    logic [8:0]  pos_wide;
    logic        lit;
    logic [2:0]  band;
    logic [23:0] colour;
    logic [191:0] pal_all;
    logic [23:0] colours [BAND_MAX];
    logic [23:0] col_rgb;

    function automatic logic [2:0] band_of(input logic [5:0] pos, input logic [47:0] lims,
                                           input logic [3:0] nb);
        logic [2:0] k;
        logic       found;
        logic [3:0] nbm1;
        begin
            nbm1  = nb - 4'd1;
            k     = nbm1[2:0];
            found = 1'b0;
            for (int b = 0; b < BAND_MAX; b++) begin
                if (!found && (4'(b) < nb) && (pos < lims[6*b +: 6])) begin
                    k     = 3'(b);
                    found = 1'b1;
                end
            end
            return k;
        end
    endfunction

    always_comb begin
        if (led_count_reg == 7'd0) begin
            leds_eff = 7'd1;
        end else if (led_count_reg > 7'(LED_MAX)) begin
            leds_eff = 7'(LED_MAX);
        end else begin
            leds_eff = led_count_reg;
        end
        if (band_count_reg == 4'd0) begin
            bands_eff = 4'd1;
        end else if (band_count_reg > 4'(BAND_MAX)) begin
            bands_eff = 4'(BAND_MAX);
        end else begin
            bands_eff = band_count_reg;
        end
    end

    // Level mapping: (sample - 15) * leds / 995 by reciprocal with one correction
    assign diff      = (sample_reg >= 10'(SAMPLE_OFFSET)) ? sample_reg - 10'(SAMPLE_OFFSET)
                                                          : 10'd0;
    assign prod_full = 17'(diff) * 17'(leds_eff);
    assign qmul      = 27'(prod_reg) * 27'(RECIP);
    assign back      = 17'(qest_reg) * 17'(SAMPLE_SPAN);
    assign rem       = {1'b0, prod_reg} - back;

    always_comb begin
        qcor = (rem >= 17'(SAMPLE_SPAN)) ? qest_reg + 7'd1 : qest_reg;
        if (qcor > leds_eff) begin
            qcor = leds_eff;
        end
        direct_lvl = (level_in_reg > {1'b0, leds_eff}) ? leds_eff : level_in_reg[6:0];
        lvl_set    = (shown_level_reg > leds_eff) ? leds_eff : shown_level_reg;
        start_set  = ((tail_length_reg != 7'd0) && (lvl_set > tail_length_reg))
                     ? lvl_set - tail_length_reg : 7'd0;
        sband_pos  = (lvl_set != 7'd0) ? 6'(lvl_set - 7'd1) : 6'd0;
    end

    // Per-LED result
    assign pal_all = {pal_high_reg, pal_mid_reg, pal_low_reg};
    assign cols    = layout_reg[5:2];
    assign rows    = layout_reg[9:6];

    always_comb begin
        for (int k = 0; k < BAND_MAX; k++) begin
            colours[k] = pal_all[24*k +: 24];
        end
        full_row = layout_reg[0] && (cols != 4'd0) && (row_reg < rows)
                   && ((9'(row_base_reg) + 9'(cols)) <= 9'(leds_eff));
        if (full_row && row_reg[0]) begin
            pos_wide = 9'(row_base_reg) + 9'(cols) - 9'd1 - 9'(col_reg);
        end else begin
            pos_wide = 9'(idx_reg);
        end
        lit     = (idx_reg >= start_reg) && (idx_reg < lvl_reg);
        band    = layout_reg[1] ? sband_reg
                                : band_of(idx_reg[5:0], band_limits_reg, bands_eff);
        colour  = colours[band];
        col_rgb = lit ? colour : 24'd0;
    end

    assign stat.pending  = pending_reg;
    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.last_led = (idx_reg == (leds_eff - 7'd1));

    // Configuration and level state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg   <= 7'd8;
            band_count_reg  <= 4'd1;
            band_limits_reg <= '0;
            tail_length_reg <= '0;
            layout_reg      <= '0;
            pal_low_reg     <= '0;
            pal_mid_reg     <= '0;
            pal_high_reg    <= '0;
            shown_level_reg <= '0;
            prior_pot_reg   <= '0;
            pending_reg     <= 1'b1;
        end else begin
            if (cfg_we) begin
                pending_reg <= 1'b1;
                unique case (lbg_reg_t'(cfg_index))
                    REG_LED_COUNT:    led_count_reg   <= cfg_wdata[6:0];
                    REG_BAND_COUNT:   band_count_reg  <= cfg_wdata[3:0];
                    REG_BAND_LIMITS:  band_limits_reg <= cfg_wdata[47:0];
                    REG_TAIL_LENGTH:  tail_length_reg <= cfg_wdata[6:0];
                    REG_LAYOUT_MODE:  layout_reg      <= cfg_wdata[9:0];
                    REG_PALETTE_LOW:  pal_low_reg     <= cfg_wdata;
                    REG_PALETTE_MID:  pal_mid_reg     <= cfg_wdata;
                    REG_PALETTE_HIGH: pal_high_reg    <= cfg_wdata;
                endcase
            end
            if (cmd.update) begin
                if (func_reg) begin
                    shown_level_reg <= direct_lvl;
                    pending_reg     <= 1'b1;
                end else if (qfin_reg != prior_pot_reg) begin
                    shown_level_reg <= qfin_reg;
                    prior_pot_reg   <= qfin_reg;
                    pending_reg     <= 1'b1;
                end
            end
            if (cmd.setup) begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Request capture and multiply steps
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg     <= s_tuser;
            sample_reg   <= s_tdata[9:0];
            level_in_reg <= s_tdata[17:10];
        end
        if (cmd.mul1) begin
            prod_reg <= prod_full[15:0];
        end
        if (cmd.mul2) begin
            qest_reg <= qmul[26:RECIP_SHIFT];
        end
        if (cmd.mul3) begin
            qfin_reg <= qcor;
        end
        if (cmd.setup) begin
            lvl_reg   <= lvl_set;
            start_reg <= start_set;
            sband_reg <= band_of(sband_pos, band_limits_reg, bands_eff);
        end
    end

    // Frame counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end else if (cmd.setup) begin
            idx_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end else if (cmd.emit) begin
            idx_reg <= idx_reg + 7'd1;
            if (cols != 4'd0) begin
                if (col_reg == cols - 4'd1) begin
                    col_reg <= '0;
                    // saturate: rows past fifteen never map serpentine
                    if (row_reg != 4'hF) begin
                        row_reg      <= row_reg + 4'd1;
                        row_base_reg <= row_base_reg + 8'(cols);
                    end
                end else begin
                    col_reg <= col_reg + 4'd1;
                end
            end
        end
    end

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {1'b0, col_rgb[7:0], col_rgb[15:8], col_rgb[23:16], lit,
                           pos_wide[5:0]};
            m_last_reg <= stat.last_led;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/led_bar_graph_renderer.sv */
// Top level of the LED bar-graph renderer: controller plus datapath.
// Depends on lbg_pkg, lbg_ctrl and lbg_dp.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata: sample, level; s_tuser: func
//  m_       out        m_tvalid/m_tready  m_tdata: position..blue; m_tlast: last
//  cfg_     in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// A request is mapped to a level by capture, three multiply steps
// through the reciprocal divider and update, followed by setup; if a
// redraw follows, the frame walk emits one LED per cycle while the
// output stage is free. A new request is taken only back in idle.
// The frame walk is the bottleneck: one LED result per cycle through the
// single output register. Reset is synchronous, active low, and schedules
// a redraw. A stalled m_tready holds the result and pauses the walk.
module led_bar_graph_renderer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lbg_pkg::IN_DATA_W-1:0]       s_tdata,  // [9:0] sample, [17:10] level
    input  logic                                s_tuser,  // [0] func: 1 direct level
    // LED results out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lbg_pkg::OUT_DATA_W-1:0]      m_tdata,  // [5:0] position, [6] lit,
                                                          // [14:7] red, [22:15] green,
                                                          // [30:23] blue
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [lbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import lbg_pkg::*;

    lbg_cmd_t  cmd;
    lbg_stat_t stat;

    // Sequence each request: map, update, then walk the frame if a redraw is due
    lbg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold config, compute the level and produce one LED result per emit
    lbg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
